FILE: src/ddas_pkg.sv
// ----------------------------------------------------------------------------
// ddas_pkg: shared definitions for the decimal digit add/subtract block
// Holds the digit constants, result codes and the per-digit step result
// that passes from the digit unit to the sequencer.
// ----------------------------------------------------------------------------
package ddas_pkg;

	// Default store depth in decimal digits.
	localparam int DEFAULT_MAX_DIGITS = 16;

	// Largest decimal digit and the radix.
	localparam logic [3:0] DIGIT_MAX = 4'd9;
	localparam logic [4:0] RADIX     = 5'd10;

	// Result codes carried in the which field.
	typedef enum logic [1:0] {
		WH_SUM      = 2'd0,
		WH_DIFF     = 2'd1,
		WH_UNAVAIL  = 2'd2,
		WH_TOO_LONG = 2'd3
	} which_t;

	// Outcome of one digit position of the add and subtract pass.
	typedef struct packed {
		logic [3:0] sum_digit;
		logic       carry;
		logic [3:0] diff_digit;
		logic       borrow;
	} digit_step_t;

endpackage

FILE: src/ddas_ram.sv
// ----------------------------------------------------------------------------
// ddas_ram: generic simple dual-port RAM
// One write port and one read port; the read data is registered and holds
// its value while no read is enabled.
// ----------------------------------------------------------------------------
module ddas_ram #(
	parameter int WIDTH = 4,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic             re,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// Registered read port.
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

FILE: src/ddas_digit_unit.sv
// ----------------------------------------------------------------------------
// ddas_digit_unit: one decimal digit position of add and subtract
// Forms a + b + carry and a - b - borrow for one digit, with decimal
// correction of both results.
// ----------------------------------------------------------------------------
module ddas_digit_unit
	import ddas_pkg::*;
(
	input  logic [3:0]  a,
	input  logic [3:0]  b,
	input  logic        carry_in,
	input  logic        borrow_in,
	output digit_step_t step
);

	logic [4:0] sum_raw;
	logic [4:0] diff_raw;
	logic [4:0] diff_fix;
	logic [4:0] sum_fix;

	// Binary sum and difference of the two digits.
	assign sum_raw  = {1'b0, a} + {1'b0, b} + {4'd0, carry_in};
	assign diff_raw = {1'b0, a} - {1'b0, b} - {4'd0, borrow_in};
	assign sum_fix  = sum_raw - RADIX;
	assign diff_fix = diff_raw + RADIX;

	// Decimal correction: a sum of ten or more carries, a negative
	// difference borrows.
	always_comb begin
		step.carry  = (sum_raw >= RADIX);
		step.borrow = diff_raw[4];
		step.sum_digit  = step.carry  ? sum_fix[3:0]  : sum_raw[3:0];
		step.diff_digit = step.borrow ? diff_fix[3:0] : diff_raw[3:0];
	end

endmodule

FILE: src/decimal_digit_add_subtract.sv
// ----------------------------------------------------------------------------
// decimal_digit_add_subtract: multi-digit decimal adder and subtractor
// Loads two decimal numbers most significant digit first, then emits their
// sum and, unless negative, their difference (first minus second) as digits.
// ----------------------------------------------------------------------------
//
// Channel  Dir  Word contents
// s_*      in   tuser: kind; tdata[3:0]: digit; tlast: last digit of number
// m_*      out  tuser: which; tdata[3:0]: digit_res; tlast: last_res
//
// Each significant input digit that fits is written into its digit RAM; the
// final digit of the second number starts a pass over both digit RAMs
// through the shared digit unit, or, if a digit was dropped, a status word.
// Each sum or difference digit word is then read from its RAM and then shown
// on the output; a leading carry digit and a status word go straight out.
// A stall on m_* holds the current word; no input is taken during a run.
// Reset clears the counts and the control state; no RAM clearing is needed.
// ----------------------------------------------------------------------------
module decimal_digit_add_subtract
	import ddas_pkg::*;
#(
	parameter int MAX_DIGITS = DEFAULT_MAX_DIGITS
) (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       s_tvalid,
	output logic       s_tready,
	input  logic [7:0] s_tdata,   // [3:0] digit, [7:4] zero
	input  logic       s_tuser,   // [0] kind
	input  logic       s_tlast,
	output logic       m_tvalid,
	input  logic       m_tready,
	output logic [7:0] m_tdata,   // [3:0] digit_res, [7:4] zero
	output logic [1:0] m_tuser,   // [1:0] which
	output logic       m_tlast
);

	localparam int IW = (MAX_DIGITS > 1) ? $clog2(MAX_DIGITS) : 1;
	localparam int CW = $clog2(MAX_DIGITS + 1);
	localparam logic [CW-1:0] FULL_C = CW'(MAX_DIGITS);
	localparam logic [CW-1:0] ONE_C  = CW'(1);

	typedef enum logic [6:0] {
		ST_IDLE    = 7'b0000001,
		ST_ADD     = 7'b0000010,
		ST_FLUSH   = 7'b0000100,
		ST_START   = 7'b0001000,
		ST_SUM_RD  = 7'b0010000,
		ST_DIFF_RD = 7'b0100000,
		ST_OUT     = 7'b1000000
	} state_t;

	typedef enum logic [3:0] {
		PH_CARRY = 4'b0001,
		PH_SUM   = 4'b0010,
		PH_DIFF  = 4'b0100,
		PH_STAT  = 4'b1000
	} phase_t;

	state_t      state_q;
	phase_t      phase_q;
	logic [CW-1:0] first_count_q;
	logic [CW-1:0] second_count_q;
	logic        too_long_q;
	logic [CW-1:0] pos_q;
	logic [CW-1:0] epos_q;
	logic [CW-1:0] dlen_q;
	logic        carry_q;
	logic        borrow_q;
	which_t      stat_q;

	logic        s1_valid_s1;
	logic [CW-1:0] pos_s1;
	logic        in_a_s1;
	logic        in_b_s1;

	logic        in_acc;
	logic        out_acc;
	logic [3:0]  digit_in;
	logic        kind_in;
	logic [CW-1:0] load_count;
	logic        load_skip;
	logic        load_full;
	logic        load_we;
	logic        load_drop;
	logic        too_long_next;
	logic        run_start;

	logic [CW-1:0] len_c;
	logic [CW-1:0] len_m1;
	logic [CW-1:0] addr_a_c;
	logic [CW-1:0] addr_b_c;
	logic        rd_ab;
	logic        rd_sum;
	logic        rd_diff;
	logic [CW-1:0] rd_epos;

	logic [3:0]  first_rdata;
	logic [3:0]  second_rdata;
	logic [3:0]  sum_rdata;
	logic [3:0]  diff_rdata;
	logic [3:0]  op_a;
	logic [3:0]  op_b;
	digit_step_t step;

	logic [3:0]  out_digit;
	which_t      out_which;
	logic        out_last;

	// Input handshake and digit clamping.
	assign s_tready = (state_q == ST_IDLE);
	assign in_acc   = s_tvalid & s_tready;
	assign kind_in  = s_tuser;
	assign digit_in = (s_tdata[3:0] > DIGIT_MAX) ? DIGIT_MAX : s_tdata[3:0];

	// Leading zeros are skipped; a significant digit beyond the store is dropped.
	assign load_count    = kind_in ? second_count_q : first_count_q;
	assign load_skip     = (load_count == '0) && (digit_in == 4'd0);
	assign load_full     = (load_count >= FULL_C);
	assign load_we       = in_acc & ~load_skip & ~load_full;
	assign load_drop     = in_acc & ~load_skip & load_full;
	assign too_long_next = too_long_q | load_drop;
	assign run_start     = in_acc & kind_in & s_tlast;

	// Length of the add pass and read addresses, least significant digit first.
	assign len_c    = (first_count_q > second_count_q) ? first_count_q :
		((second_count_q == '0) ? ONE_C : second_count_q);
	assign len_m1   = len_c - ONE_C;
	assign addr_a_c = first_count_q - ONE_C - pos_q;
	assign addr_b_c = second_count_q - ONE_C - pos_q;
	assign rd_ab    = (state_q == ST_ADD);
	assign rd_sum   = (state_q == ST_SUM_RD);
	assign rd_diff  = (state_q == ST_DIFF_RD);
	assign rd_epos  = epos_q;

	ddas_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_first_ram (
		.clk   (clk),
		.we    (load_we & ~kind_in),
		.waddr (load_count[IW-1:0]),
		.wdata (digit_in),
		.re    (rd_ab),
		.raddr (addr_a_c[IW-1:0]),
		.rdata (first_rdata)
	);

	ddas_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_second_ram (
		.clk   (clk),
		.we    (load_we & kind_in),
		.waddr (load_count[IW-1:0]),
		.wdata (digit_in),
		.re    (rd_ab),
		.raddr (addr_b_c[IW-1:0]),
		.rdata (second_rdata)
	);

	// Digits above the stored length read as zero.
	assign op_a = in_a_s1 ? first_rdata  : 4'd0;
	assign op_b = in_b_s1 ? second_rdata : 4'd0;

	ddas_digit_unit u_digit_unit (
		.a         (op_a),
		.b         (op_b),
		.carry_in  (carry_q),
		.borrow_in (borrow_q),
		.step      (step)
	);

	ddas_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_sum_ram (
		.clk   (clk),
		.we    (s1_valid_s1),
		.waddr (pos_s1[IW-1:0]),
		.wdata (step.sum_digit),
		.re    (rd_sum),
		.raddr (rd_epos[IW-1:0]),
		.rdata (sum_rdata)
	);

	ddas_ram #(.WIDTH(4), .DEPTH(MAX_DIGITS)) u_diff_ram (
		.clk   (clk),
		.we    (s1_valid_s1),
		.waddr (pos_s1[IW-1:0]),
		.wdata (step.diff_digit),
		.re    (rd_diff),
		.raddr (rd_epos[IW-1:0]),
		.rdata (diff_rdata)
	);

	// Read stage of the add pass: the position whose read data is on the RAM outputs in the same cycle.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_s1 <= 1'b0;
		end else begin
			s1_valid_s1 <= rd_ab;
		end
	end

	always_ff @(posedge clk) begin
		if (rd_ab) begin
			pos_s1  <= pos_q;
			in_a_s1 <= (pos_q < first_count_q);
			in_b_s1 <= (pos_q < second_count_q);
		end
	end

	// Output word: the read data for sum and difference digits, else a carry digit or a status word.
	always_comb begin
		case (phase_q)
			PH_CARRY: begin
				out_digit = 4'd1;
				out_which = WH_SUM;
				out_last  = 1'b0;
			end
			PH_SUM: begin
				out_digit = sum_rdata;
				out_which = WH_SUM;
				out_last  = 1'b0;
			end
			PH_DIFF: begin
				out_digit = diff_rdata;
				out_which = WH_DIFF;
				out_last  = (epos_q == '0);
			end
			default: begin
				out_digit = 4'd0;
				out_which = stat_q;
				out_last  = 1'b1;
			end
		endcase
	end

	assign m_tvalid = (state_q == ST_OUT);
	assign m_tdata  = {4'b0000, out_digit};
	assign m_tuser  = out_which;
	assign m_tlast  = out_last;
	assign out_acc  = m_tvalid & m_tready;

	// Sequencer: loading, add pass, and word by word emission.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q        <= ST_IDLE;
			phase_q        <= PH_STAT;
			first_count_q  <= '0;
			second_count_q <= '0;
			too_long_q     <= 1'b0;
			pos_q          <= '0;
			epos_q         <= '0;
			dlen_q         <= ONE_C;
			carry_q        <= 1'b0;
			borrow_q       <= 1'b0;
			stat_q         <= WH_TOO_LONG;
		end else begin
			// Digit loading into the count of the chosen number.
			if (load_we) begin
				if (kind_in) begin
					second_count_q <= second_count_q + ONE_C;
				end else begin
					first_count_q <= first_count_q + ONE_C;
				end
			end
			if (load_drop) begin
				too_long_q <= 1'b1;
			end

			// Carry, borrow and significant length follow each digit position.
			if (s1_valid_s1) begin
				carry_q  <= step.carry;
				borrow_q <= step.borrow;
				if (step.diff_digit != 4'd0) begin
					dlen_q <= pos_s1 + ONE_C;
				end
			end

			case (state_q)
				ST_IDLE: begin
					if (run_start) begin
						pos_q    <= '0;
						dlen_q   <= ONE_C;
						carry_q  <= 1'b0;
						borrow_q <= 1'b0;
						if (too_long_next) begin
							phase_q <= PH_STAT;
							stat_q  <= WH_TOO_LONG;
							state_q <= ST_OUT;
						end else begin
							state_q <= ST_ADD;
						end
					end
				end
				ST_ADD: begin
					pos_q <= pos_q + ONE_C;
					if (pos_q == len_m1) begin
						state_q <= ST_FLUSH;
					end
				end
				ST_FLUSH: begin
					state_q <= ST_START;
				end
				ST_START: begin
					epos_q <= len_m1;
					if (carry_q) begin
						phase_q <= PH_CARRY;
						state_q <= ST_OUT;
					end else begin
						phase_q <= PH_SUM;
						state_q <= ST_SUM_RD;
					end
				end
				ST_SUM_RD: begin
					state_q <= ST_OUT;
				end
				ST_DIFF_RD: begin
					state_q <= ST_OUT;
				end
				ST_OUT: begin
					if (out_acc) begin
						if (out_last) begin
							// End of run: the block is empty again.
							first_count_q  <= '0;
							second_count_q <= '0;
							too_long_q     <= 1'b0;
							state_q        <= ST_IDLE;
						end else if (phase_q == PH_CARRY) begin
							phase_q <= PH_SUM;
							state_q <= ST_SUM_RD;
						end else if (phase_q == PH_SUM && epos_q == '0) begin
							// A final borrow means the second number is larger.
							if (borrow_q) begin
								phase_q <= PH_STAT;
								stat_q  <= WH_UNAVAIL;
							end else begin
								phase_q <= PH_DIFF;
								epos_q  <= dlen_q - ONE_C;
								state_q <= ST_DIFF_RD;
							end
						end else begin
							epos_q  <= epos_q - ONE_C;
							state_q <= (phase_q == PH_DIFF) ? ST_DIFF_RD : ST_SUM_RD;
						end
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

endmodule
